/* hdl/olid_pkg.sv */
// Shared types and constants for the ordered list block.
// No dependencies; used by olid_cell and ordered_list_insert_delete_top.
package olid_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned GROUP        = 16;
  localparam int unsigned GROUP_W      = $clog2(GROUP);

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_LOCATE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE,
    OP_INSERT,
    OP_DELETE,
    OP_MARK_POS,
    OP_MATCH
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    cell_op_e            op;
    logic [DATA_W-1:0]   value;
  } cell_cmd_t;

endpackage

/* hdl/olid_cell.sv */
// One list slot: holds one entry and one flag bit.
// Depends on olid_pkg (cell_cmd_t, cell_op_e, DATA_W).
module olid_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  olid_pkg::cell_cmd_t       cmd_i,
  input  logic [CNT_W-1:0]          pos_i,
  input  logic [CNT_W-1:0]          cnt_i,
  input  logic [olid_pkg::DATA_W-1:0] left_i,
  input  logic [olid_pkg::DATA_W-1:0] right_i,
  output logic [olid_pkg::DATA_W-1:0] data_o,
  output logic                      flag_o
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [olid_pkg::DATA_W-1:0] data_q, data_d;
  logic                        flag_q, flag_d;

  always_comb begin
    data_d = data_q;
    flag_d = flag_q;
    case (cmd_i.op)
      olid_pkg::OP_WRITE: begin
        if (MY_IDX == pos_i) data_d = cmd_i.value;
      end
      olid_pkg::OP_INSERT: begin
        if (MY_IDX == pos_i)     data_d = cmd_i.value;
        else if (MY_IDX > pos_i) data_d = left_i;
      end
      olid_pkg::OP_DELETE: begin
        if (MY_IDX >= pos_i) data_d = right_i;
      end
      olid_pkg::OP_MARK_POS: flag_d = (MY_IDX == pos_i);
      olid_pkg::OP_MATCH:    flag_d = (data_q == cmd_i.value) && (MY_IDX < cnt_i);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign data_o = data_q;
  assign flag_o = flag_q;

endmodule

/* hdl/ordered_list_insert_delete_top.sv */
// Ordered list of signed 32-bit words: append, insert, delete, locate.
// Depends on olid_pkg and olid_cell.
//
// The list lives in a row of CAPACITY cells, one entry per cell, with a length
// counter beside it. Append writes the cell past the last entry; insert and
// delete move every affected entry by one cell at once, each cell loading from
// its left or right neighbor. Locate compares all cells at once into per-cell
// flag bits, then a scanner walks the flags 16 cells per cycle to find the first
// match; delete marks the target cell the same way and reads the removed word
// from its 16-cell group. Append, insert and rejected requests go from accept
// straight to the finish state; delete passes through the scan state; locate
// scans groups in order up to the one that holds the first match (all
// ceil(CAPACITY/16) groups when nothing matches). The group scan sets
// the locate time. A result sits in an output register, so the next request is
// taken while it waits for transfer; a request whose result finds that register
// still stalled waits for it before the block takes another.
// Entries past the current length are never read. At CAPACITY above 255 the
// position port reaches only 1 to 255 and the 8-bit result fields carry low bits.
module ordered_list_insert_delete_top #(
  parameter int unsigned CAPACITY = olid_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [olid_pkg::POS_W-1:0]  position_i,
  input  logic signed [olid_pkg::DATA_W-1:0] value_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic signed [olid_pkg::DATA_W-1:0] removed_value_o,
  output logic [olid_pkg::POS_W-1:0]  found_position_o,
  output logic [olid_pkg::POS_W-1:0]  list_length_o
);

  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W     = ((CNT_W > olid_pkg::POS_W) ? CNT_W : olid_pkg::POS_W) + 1;
  localparam int unsigned NGRP      = (CAPACITY + olid_pkg::GROUP - 1) / olid_pkg::GROUP;
  localparam int unsigned GRP_IDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned PAD       = NGRP * olid_pkg::GROUP;
  localparam int unsigned FIDX_W    = GRP_IDX_W + olid_pkg::GROUP_W;
  localparam int unsigned DW        = olid_pkg::DATA_W;

  localparam logic [CNT_W-1:0]     CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [GRP_IDX_W-1:0] LAST_GRP = GRP_IDX_W'(NGRP - 1);

  // ---------------------------------------------------------------- control
  olid_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  olid_pkg::kind_e   kind_q, kind_d;
  logic [CNT_W-1:0]  pidx_q, pidx_d;       // zero-based target slot
  olid_pkg::status_e stat_q, stat_d;
  logic [GRP_IDX_W-1:0] grp_q, grp_d;
  logic [CNT_W-1:0]  found_q, found_d;
  logic [DW-1:0]     removed_q, removed_d;

  // output register
  logic                 out_valid_q;
  olid_pkg::status_e    out_stat_q;
  logic [DW-1:0]        out_removed_q;
  logic [olid_pkg::POS_W-1:0] out_found_q, out_len_q;
  logic                 out_load;

  // cell chain
  olid_pkg::cell_cmd_t cmd;
  logic [CNT_W-1:0]    cmd_pos;
  logic [DW-1:0]       cell_data [CAPACITY];
  logic [PAD-1:0]      flags;
  logic [DW-1:0]       masked [PAD];
  logic [DW-1:0]       grp_or [NGRP];

  // request decode
  olid_pkg::kind_e   kind_in;
  logic [CMP_W-1:0]  pos_c, cnt_c, pos_m1;
  logic [CNT_W-1:0]  pidx_in;
  logic              full, ins_ok, del_ok;

  // scanner
  logic [olid_pkg::GROUP-1:0]   grp_flags;
  logic [olid_pkg::GROUP_W-1:0] enc;
  logic [FIDX_W:0]              found_full;

  assign kind_in = olid_pkg::kind_e'(kind_i);
  assign pos_c   = CMP_W'(position_i);
  assign cnt_c   = CMP_W'(count_q);
  assign pos_m1  = pos_c - CMP_W'(1);
  assign pidx_in = CNT_W'(pos_m1);
  assign full    = (count_q == CAP_CNT);
  assign ins_ok  = (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1));
  assign del_ok  = (pos_c != '0) && (pos_c <= cnt_c);

  // ------------------------------------------------------------- cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left, right;
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    olid_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .pos_i   (cmd_pos),
      .cnt_i   (count_q),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .flag_o  (flags[i])
    );

    assign masked[i] = cell_data[i] & {DW{flags[i]}};
  end

  for (genvar i = CAPACITY; i < PAD; i++) begin : g_pad
    assign flags[i]  = 1'b0;
    assign masked[i] = '0;
  end

  // per-group OR of flagged words; only one cell is flagged on delete
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_or[g] = '0;
      for (int k = 0; k < olid_pkg::GROUP; k++) begin
        grp_or[g] = grp_or[g] | masked[g*olid_pkg::GROUP + k];
      end
    end
  end

  assign grp_flags = flags[grp_q*olid_pkg::GROUP +: olid_pkg::GROUP];

  // first flagged cell within the current group
  always_comb begin
    enc = '0;
    for (int k = olid_pkg::GROUP - 1; k >= 0; k--) begin
      if (grp_flags[k]) enc = olid_pkg::GROUP_W'(k);
    end
  end

  assign found_full = {1'b0, grp_q, enc} + (FIDX_W + 1)'(1);

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    kind_d    = kind_q;
    pidx_d    = pidx_q;
    stat_d    = stat_q;
    grp_d     = grp_q;
    found_d   = found_q;
    removed_d = removed_q;
    cmd.op    = olid_pkg::OP_HOLD;
    cmd.value = value_i;
    cmd_pos   = pidx_in;
    out_load  = 1'b0;

    case (state_q)
      olid_pkg::S_IDLE: begin
        if (in_valid_i) begin
          kind_d    = kind_in;
          pidx_d    = pidx_in;
          stat_d    = olid_pkg::ST_OK;
          grp_d     = '0;
          found_d   = '0;
          removed_d = '0;
          state_d   = olid_pkg::S_FIN;
          case (kind_in)
            olid_pkg::KIND_APPEND: begin
              if (full) begin
                stat_d = olid_pkg::ST_FULL;
              end else begin
                cmd.op  = olid_pkg::OP_WRITE;
                cmd_pos = count_q;
                count_d = count_q + CNT_W'(1);
              end
            end
            olid_pkg::KIND_INSERT: begin
              if (full) begin
                stat_d = olid_pkg::ST_FULL;
              end else if (!ins_ok) begin
                stat_d = olid_pkg::ST_BADPOS;
              end else begin
                cmd.op  = olid_pkg::OP_INSERT;
                count_d = count_q + CNT_W'(1);
              end
            end
            olid_pkg::KIND_DELETE: begin
              if (!del_ok) begin
                stat_d = olid_pkg::ST_BADPOS;
              end else begin
                cmd.op  = olid_pkg::OP_MARK_POS;
                grp_d   = GRP_IDX_W'(pidx_in >> olid_pkg::GROUP_W);
                state_d = olid_pkg::S_SCAN;
              end
            end
            default: begin
              cmd.op  = olid_pkg::OP_MATCH;
              state_d = olid_pkg::S_SCAN;
            end
          endcase
        end
      end

      olid_pkg::S_SCAN: begin
        if (kind_q == olid_pkg::KIND_DELETE) begin
          // read the marked word, then close the gap in the same edge
          removed_d = grp_or[grp_q];
          cmd.op    = olid_pkg::OP_DELETE;
          cmd_pos   = pidx_q;
          count_d   = count_q - CNT_W'(1);
          state_d   = olid_pkg::S_FIN;
        end else if (|grp_flags) begin
          found_d = CNT_W'(found_full);
          state_d = olid_pkg::S_FIN;
        end else if (grp_q == LAST_GRP) begin
          stat_d  = olid_pkg::ST_NOTFOUND;
          state_d = olid_pkg::S_FIN;
        end else begin
          grp_d = grp_q + GRP_IDX_W'(1);
        end
      end

      olid_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = olid_pkg::S_IDLE;
        end
      end

      default: state_d = olid_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olid_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    pidx_q    <= pidx_d;
    stat_q    <= stat_d;
    grp_q     <= grp_d;
    found_q   <= found_d;
    removed_q <= removed_d;
    if (out_load) begin
      out_stat_q    <= stat_q;
      out_removed_q <= removed_q;
      out_found_q   <= olid_pkg::POS_W'(found_q);
      out_len_q     <= olid_pkg::POS_W'(count_q);
    end
  end

  assign in_stall_o       = (state_q != olid_pkg::S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_stat_q;
  assign removed_value_o  = out_removed_q;
  assign found_position_o = out_found_q;
  assign list_length_o    = out_len_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("list length above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) ||
    (count_q == CNT_W'($past(count_q) + CNT_W'(1))) ||
    (count_q == CNT_W'($past(count_q) - CNT_W'(1))))
    else $error("list length moved by more than one");

  a_delete_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == olid_pkg::S_SCAN) && (kind_q == olid_pkg::KIND_DELETE) |->
    $onehot(grp_flags))
    else $error("delete target not marked in its group");

  a_locate_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == olid_pkg::S_FIN) && (kind_q == olid_pkg::KIND_LOCATE) &&
    (stat_q == olid_pkg::ST_OK) |-> (found_q != '0) && (found_q <= count_q))
    else $error("locate hit outside the list");
`endif

endmodule

/* tb/sv/list_check_pkg.sv */
`timescale 1ns / 100ps
// Shadow copy of the ordered list and the queue of expected results.
// Depends on olid_pkg; used by tb_top.
package list_check_pkg;
  import olid_pkg::*;

  localparam int unsigned LIST_CAP = CAPACITY_DEF;

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] removed;
    logic [POS_W-1:0]         found;
    logic [POS_W-1:0]         length;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] words [LIST_CAP];
    int unsigned              held;
    list_result_t             expected_q [$];
    int unsigned              errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // Apply one accepted request to the shadow list and queue its result.
    function void note_request(kind_e kind, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_result_t r;
      int unsigned  i;
      r.status  = ST_OK;
      r.removed = '0;
      r.found   = '0;
      case (kind)
        KIND_APPEND: begin
          if (held >= LIST_CAP) begin
            r.status = ST_FULL;
          end else begin
            words[held] = val;
            held++;
          end
        end
        KIND_INSERT: begin
          // full wins over a bad position
          if (held >= LIST_CAP) begin
            r.status = ST_FULL;
          end else if (pos < 1 || pos > held + 1) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = held; i >= pos; i--) words[i] = words[i-1];
            words[pos-1] = val;
            held++;
          end
        end
        KIND_DELETE: begin
          if (pos < 1 || pos > held) begin
            r.status = ST_BADPOS;
          end else begin
            r.removed = words[pos-1];
            for (i = pos; i < held; i++) words[i-1] = words[i];
            held--;
          end
        end
        default: begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < held; i++) begin
            if (words[i] == val) begin
              r.found  = POS_W'(i + 1);
              r.status = ST_OK;
              break;
            end
          end
        end
      endcase
      r.length = POS_W'(held);
      expected_q.push_back(r);
    endfunction

    // Compare one transferred result with the oldest expectation.
    function void check_result(logic [1:0] status, logic signed [DATA_W-1:0] removed,
                               logic [POS_W-1:0] found, logic [POS_W-1:0] length);
      list_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: status %0d length %0d",
                 $time, status, length);
        return;
      end
      e = expected_q.pop_front();
      if (status !== e.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
      end
      if (removed !== e.removed) begin
        errors++;
        $display("%0t: removed_value expected %0d actual %0d", $time, e.removed, removed);
      end
      if (found !== e.found) begin
        errors++;
        $display("%0t: found_position expected %0d actual %0d", $time, e.found, found);
      end
      if (length !== e.length) begin
        errors++;
        $display("%0t: list_length expected %0d actual %0d", $time, e.length, length);
      end
    endfunction
  endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for ordered_list_insert_delete_top: directed and random
// list traffic under varied handshake pressure. Depends on olid_pkg, list_check_pkg.
module tb_top;
  import olid_pkg::*;
  import list_check_pkg::*;

  // The watchdog limit leaves ample margin over the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 300000;
  // Drain window after the last result: locate may walk all 8 groups.
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS = 100;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     req_valid;
  logic                     req_stall;
  kind_e                    req_kind;
  logic [POS_W-1:0]         req_position;
  logic signed [DATA_W-1:0] req_value;
  logic                     res_valid;
  logic                     res_stall;
  logic [1:0]               res_status;
  logic signed [DATA_W-1:0] res_removed;
  logic [POS_W-1:0]         res_found;
  logic [POS_W-1:0]         res_length;

  // Idle/stall odds in percent, changed per phase.
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned cycles;

  // Random traffic alternates between growing the list to capacity
  // (and lingering there to hit the full status) and draining it to empty.
  bit          growing;
  int unsigned full_hits;

  list_scoreboard sb;

  ordered_list_insert_delete_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (req_valid),
    .in_stall_o       (req_stall),
    .kind_i           (req_kind),
    .position_i       (req_position),
    .value_i          (req_value),
    .out_valid_o      (res_valid),
    .out_stall_i      (res_stall),
    .status_o         (res_status),
    .removed_value_o  (res_removed),
    .found_position_o (res_found),
    .list_length_o    (res_length)
  );

  always #5 clk_i = ~clk_i;

  // Result side: check each transfer, then pick the stall for the next cycle.
  // Sampling in the active region sees pre-edge values, since the block and
  // this bench both update through nonblocking assignments.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid && !res_stall) begin
      sb.check_result(res_status, res_removed, res_found, res_length);
    end
    res_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Present one request and hold it until the transfer, then maybe go idle.
  // Valid stays high straight into the next request when no gap is chosen.
  task automatic send_request(kind_e kind, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    req_valid    <= 1'b1;
    req_kind     <= kind;
    req_position <= pos;
    req_value    <= val;
    do @(posedge clk_i); while (req_stall);
    sb.note_request(kind, pos, val);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Word mix: wide random, a tiny pool that makes duplicates, the extremes,
  // and copies of words already held.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r <= 3) return $urandom;
    if (r <= 6) return int'($urandom_range(8)) - 4;
    if (r == 7) return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    if (sb.held == 0) return $urandom;
    return sb.words[$urandom_range(sb.held - 1)];
  endfunction

  // Mostly legal positions 1..top, some at or just outside the edges, some anywhere in 8 bits.
  function automatic logic [POS_W-1:0] pick_position(int unsigned top);
    int unsigned r;
    r = $urandom_range(99);
    if (top == 0 || r >= 90) return POS_W'($urandom_range(255));
    if (r >= 80) begin
      case ($urandom_range(2))
        0:       return '0;
        1:       return POS_W'(top + 1);
        default: return POS_W'(top);
      endcase
    end
    return POS_W'($urandom_range(top, 1));
  endfunction

  task automatic random_traffic(int unsigned n);
    int unsigned      r;
    kind_e            kind;
    logic [POS_W-1:0] pos;
    repeat (n) begin
      if (growing && sb.held == LIST_CAP) begin
        full_hits++;
        if (full_hits >= 12) growing = 1'b0;
      end
      if (!growing && sb.held == 0) begin
        growing   = 1'b1;
        full_hits = 0;
      end
      r = $urandom_range(99);
      if (growing) begin
        kind = r < 45 ? KIND_APPEND : r < 85 ? KIND_INSERT : r < 93 ? KIND_DELETE : KIND_LOCATE;
      end else begin
        kind = r < 8 ? KIND_APPEND : r < 16 ? KIND_INSERT : r < 80 ? KIND_DELETE : KIND_LOCATE;
      end
      case (kind)
        KIND_INSERT: begin
          // at capacity, throw any position so full is seen over bad positions too
          pos = (sb.held >= LIST_CAP) ? POS_W'($urandom_range(255)) : pick_position(sb.held + 1);
          send_request(kind, pos, pick_value());
        end
        KIND_DELETE: send_request(kind, pick_position(sb.held), $urandom);
        KIND_LOCATE: begin
          if (sb.held != 0 && $urandom_range(99) < 60) begin
            send_request(kind, POS_W'($urandom_range(255)),
                         sb.words[$urandom_range(sb.held - 1)]);
          end else begin
            send_request(kind, POS_W'($urandom_range(255)), pick_value());
          end
        end
        default: send_request(kind, POS_W'($urandom_range(255)), pick_value());
      endcase
    end
  endtask

  initial begin
    sb           = new();
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    req_valid    = 1'b0;
    req_kind     = KIND_APPEND;
    req_position = '0;
    req_value    = '0;
    res_stall    = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    cycles       = 0;
    growing      = 1'b1;
    full_hits    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list rejects, edges of the insert and delete windows,
    // extreme words, duplicates (first match wins), and a miss.
    send_request(KIND_LOCATE, 8'd0,   32'sd5);
    send_request(KIND_DELETE, 8'd1,   32'sd0);
    send_request(KIND_DELETE, 8'd0,   32'sd0);
    send_request(KIND_INSERT, 8'd0,   32'sd1);
    send_request(KIND_INSERT, 8'd2,   32'sd1);
    send_request(KIND_INSERT, 8'd1,   32'sh7fff_ffff);
    send_request(KIND_APPEND, 8'd255, 32'sh8000_0000);
    send_request(KIND_APPEND, 8'd0,   32'sd0);
    send_request(KIND_INSERT, 8'd4,   -32'sd1);
    send_request(KIND_INSERT, 8'd2,   32'sh7fff_ffff);
    send_request(KIND_LOCATE, 8'd0,   32'sh7fff_ffff);
    send_request(KIND_LOCATE, 8'd0,   -32'sd1);
    send_request(KIND_LOCATE, 8'd0,   32'sd12345);
    send_request(KIND_INSERT, 8'd255, 32'sd9);
    send_request(KIND_INSERT, 8'd7,   32'sd9);
    send_request(KIND_DELETE, 8'd6,   32'sd0);
    send_request(KIND_DELETE, 8'd255, 32'sd0);
    send_request(KIND_DELETE, 8'd5,   32'sd0);
    send_request(KIND_DELETE, 8'd1,   32'sd0);
    send_request(KIND_DELETE, 8'd2,   32'sd0);
    send_request(KIND_APPEND, 8'd128, 32'sh5555_5555);
    send_request(KIND_APPEND, 8'd129, 32'shaaaa_aaaa);
    send_request(KIND_LOCATE, 8'd0,   32'shaaaa_aaaa);
    send_request(KIND_DELETE, 8'd128, 32'sd0);

    // Random traffic in four pressure phases.
    random_traffic(PHASE_ITEMS);
    tx_idle_pct = 83;
    random_traffic(PHASE_ITEMS);
    tx_idle_pct  = 0;
    rx_stall_pct = 83;
    random_traffic(PHASE_ITEMS);
    tx_idle_pct  = 11;
    rx_stall_pct = 11;
    random_traffic(PHASE_ITEMS);
    req_valid <= 1'b0;

    // Wait for every expected result, then give stray outputs a chance to show.
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
